// File: hw/rtl/hptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_pkg
// Shared types and constants of the environment sensor compensation pipeline.
// ----------------------------------------------------------------------------
package hptc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP     = 3'd0,
        CFG_PRESS_LO = 3'd1,
        CFG_PRESS_HI = 3'd2,
        CFG_MIXED    = 3'd3,
        CFG_HUM      = 3'd4
    } cfg_idx_t;

    localparam logic signed [34:0] T_FINE_PRESS_OFS = 35'sd128000;
    localparam logic signed [31:0] T_FINE_HUM_OFS   = 32'sd76800;
    localparam logic [20:0]        PRESS_FULL_SCALE = 21'd1048576;
    localparam logic [11:0]        PRESS_SCALE      = 12'd3125;
    localparam logic signed [31:0] HUM_MAX          = 32'sd419430400;
    localparam logic [19:0]        PRESS_MAX        = 20'hFFFFF;
    // ceil(2^27 / 10): exact truncating divide by ten for magnitudes below 2^26.
    localparam logic [23:0]        TENTH_RECIP      = 24'hCCCCCD;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [47:0] mixed;
        logic [31:0] hum;
    } cfg_t;

    // Front end to divider.
    typedef struct packed {
        logic        vld;
        logic [63:0] num_mag;
        logic [30:0] den_mag;
        logic        neg;
        logic [15:0] temp;
        logic [9:0]  hum;
        logic        err;
    } div_in_t;

    // Divider to back end.
    typedef struct packed {
        logic        vld;
        logic [63:0] quot;
        logic        neg;
        logic [15:0] temp;
        logic [9:0]  hum;
        logic        err;
    } div_out_t;

    // Finished result.
    typedef struct packed {
        logic        vld;
        logic [15:0] temp;
        logic [19:0] press;
        logic [9:0]  hum;
        logic        err;
    } result_t;

endpackage

// File: hw/rtl/hptc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_front
// Eleven-stage front end: temperature, humidity, and the pressure dividend
// and divisor reduced to sign and magnitude for the divider.
// ----------------------------------------------------------------------------
module hptc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  hptc_pkg::cfg_t    cfg,
    input  logic              in_vld,
    input  logic [19:0]       in_adc_p,
    input  logic [19:0]       in_adc_t,
    input  logic [15:0]       in_adc_h,
    output hptc_pkg::div_in_t out
);
    import hptc_pkg::*;

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, h2;
    logic [7:0]         h1, h3;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = cfg.temp[15:0];
    assign t2 = $signed(cfg.temp[31:16]);
    assign t3 = $signed(cfg.temp[47:32]);
    assign p1 = cfg.press_lo[15:0];
    assign p2 = $signed(cfg.press_lo[31:16]);
    assign p3 = $signed(cfg.press_lo[47:32]);
    assign p4 = $signed(cfg.press_lo[63:48]);
    assign p5 = $signed(cfg.press_hi[15:0]);
    assign p6 = $signed(cfg.press_hi[31:16]);
    assign h1 = cfg.mixed[23:16];
    assign h2 = $signed(cfg.mixed[39:24]);
    assign h3 = cfg.mixed[47:40];
    assign h4 = $signed(cfg.hum[11:0]);
    assign h5 = $signed(cfg.hum[23:12]);
    assign h6 = $signed(cfg.hum[31:24]);

    logic [9:0] vld_reg;

    // Stage registers.
    logic signed [31:0] f1_m1_reg, f1_bb_reg, f2_v1_reg, f2_m2_reg, f3_tfine_reg;
    logic [19:0]        f1_adcp_reg, f2_adcp_reg, f3_adcp_reg, f4_adcp_reg;
    logic [19:0]        f5_adcp_reg, f6_adcp_reg, f7_adcp_reg, f8_adcp_reg;
    logic [15:0]        f1_adch_reg, f2_adch_reg, f3_adch_reg, f4_adch_reg;
    logic signed [23:0] f4_tc_reg;
    logic signed [34:0] f4_q1_reg;
    logic signed [31:0] f4_hv_reg;
    logic [47:0]        f5_tprod_reg;
    logic               f5_tneg_reg;
    logic signed [63:0] f5_sq_reg, f5_q1p5_reg, f5_q1p2_reg;
    logic signed [31:0] f5_x0_reg, f5_m6_reg, f5_m3_reg;
    logic [15:0]        f6_tq_reg, f7_tq_reg, f8_tq_reg, f9_tq_reg, f10_tq_reg;
    logic signed [63:0] f6_lo6_reg, f6_lo3_reg, f6_q1p5_reg, f6_q1p2_reg;
    logic [31:0]        f6_hi6_reg, f6_hi3_reg;
    logic signed [31:0] f6_x_reg, f6_y1_reg;
    logic signed [63:0] f7_t6_reg, f7_t3_reg, f7_q1p5_reg, f7_q1p2_reg;
    logic signed [31:0] f7_x_reg, f7_y3_reg;
    logic signed [63:0] f8_q2_reg, f8_q1b_reg;
    logic signed [31:0] f8_vv_reg;
    logic [47:0]        f9_lo1_reg;
    logic [31:0]        f9_hi1_reg;
    logic [63:0]        f9_num0_reg;
    logic signed [31:0] f9_vv_reg, f9_ww_reg;
    logic signed [30:0] f10_d_reg;
    logic [43:0]        f10_lon_reg;
    logic [31:0]        f10_hin_reg;
    logic signed [31:0] f10_vv_reg, f10_th_reg;
    div_in_t            out_reg;

    // Combinational next values.
    logic signed [31:0] a_next, b_next, tc5_next;
    logic [23:0]        tmag_next;
    logic [21:0]        tquot_next;
    logic signed [21:0] tq_wide_next;
    logic [15:0]        tq_next;
    logic signed [63:0] q1c_next, dsum_next, n_next;
    logic signed [31:0] w_next, v_next;
    logic [28:0]        sv_next;
    logic [32:0]        hprod_next;
    div_in_t            out_next;

    always_comb begin
        a_next   = $signed(32'(in_adc_t[19:3]) - 32'({t1, 1'b0}));
        b_next   = $signed(32'(in_adc_t[19:4]) - 32'(t1));
        tc5_next = f3_tfine_reg * 32'sd5 + 32'sd128;
        tmag_next = f4_tc_reg[23] ? 24'(-f4_tc_reg) : 24'(f4_tc_reg);

        tquot_next   = {1'b0, f5_tprod_reg[47:27]};
        tq_wide_next = f5_tneg_reg ? -$signed(tquot_next) : $signed(tquot_next);
        if (tq_wide_next > 22'sd32767) begin
            tq_next = 16'h7FFF;
        end else if (tq_wide_next < -22'sd32768) begin
            tq_next = 16'h8000;
        end else begin
            tq_next = tq_wide_next[15:0];
        end

        q1c_next  = f8_q1b_reg + (64'sd1 <<< 47);
        w_next    = f8_vv_reg >>> 15;
        dsum_next = $signed(64'(f9_lo1_reg) + {f9_hi1_reg, 32'b0});
        n_next    = $signed(64'(f10_lon_reg) + {f10_hin_reg, 32'b0});

        v_next = f10_vv_reg - (f10_th_reg >>> 4);
        if (v_next < 0) begin
            sv_next = '0;
        end else if (v_next > HUM_MAX) begin
            sv_next = HUM_MAX[28:0];
        end else begin
            sv_next = v_next[28:0];
        end
        hprod_next = {sv_next, 3'b0} + {3'b0, sv_next, 1'b0};

        out_next.vld     = vld_reg[9];
        out_next.num_mag = n_next[63] ? 64'(-n_next) : 64'(n_next);
        out_next.den_mag = f10_d_reg[30] ? 31'(-f10_d_reg) : 31'(f10_d_reg);
        out_next.neg     = n_next[63] ^ f10_d_reg[30];
        out_next.temp    = f10_tq_reg;
        out_next.hum     = hprod_next[31:22];
        out_next.err     = (f10_d_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[8:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Temperature.
            f1_m1_reg    <= a_next * 32'(t2);
            f1_bb_reg    <= b_next * b_next;
            f2_v1_reg    <= f1_m1_reg >>> 11;
            f2_m2_reg    <= (f1_bb_reg >>> 12) * 32'(t3);
            f3_tfine_reg <= f2_v1_reg + (f2_m2_reg >>> 14);
            f4_tc_reg    <= tc5_next[31:8];
            f5_tprod_reg <= 48'(tmag_next) * 48'(TENTH_RECIP);
            f5_tneg_reg  <= f4_tc_reg[23];
            f6_tq_reg    <= tq_next;
            f7_tq_reg    <= f6_tq_reg;
            f8_tq_reg    <= f7_tq_reg;
            f9_tq_reg    <= f8_tq_reg;
            f10_tq_reg   <= f9_tq_reg;

            // Raw codes ride along until they are used.
            f1_adcp_reg <= in_adc_p;
            f2_adcp_reg <= f1_adcp_reg;
            f3_adcp_reg <= f2_adcp_reg;
            f4_adcp_reg <= f3_adcp_reg;
            f5_adcp_reg <= f4_adcp_reg;
            f6_adcp_reg <= f5_adcp_reg;
            f7_adcp_reg <= f6_adcp_reg;
            f8_adcp_reg <= f7_adcp_reg;
            f1_adch_reg <= in_adc_h;
            f2_adch_reg <= f1_adch_reg;
            f3_adch_reg <= f2_adch_reg;
            f4_adch_reg <= f3_adch_reg;

            // Pressure dividend and divisor, all wrapping at 64 bits.
            f4_q1_reg   <= 35'(f3_tfine_reg) - T_FINE_PRESS_OFS;
            f5_sq_reg   <= 64'(f4_q1_reg) * 64'(f4_q1_reg);
            f5_q1p5_reg <= 64'(f4_q1_reg) * 64'(p5);
            f5_q1p2_reg <= 64'(f4_q1_reg) * 64'(p2);
            // 64-by-16 products split at bit 32 into two narrow partials.
            f6_lo6_reg  <= 64'($signed({1'b0, f5_sq_reg[31:0]})) * 64'(p6);
            f6_hi6_reg  <= f5_sq_reg[63:32] * 32'(p6);
            f6_lo3_reg  <= 64'($signed({1'b0, f5_sq_reg[31:0]})) * 64'(p3);
            f6_hi3_reg  <= f5_sq_reg[63:32] * 32'(p3);
            f6_q1p5_reg <= f5_q1p5_reg;
            f6_q1p2_reg <= f5_q1p2_reg;
            f7_t6_reg   <= $signed(f6_lo6_reg + {f6_hi6_reg, 32'b0});
            f7_t3_reg   <= $signed(f6_lo3_reg + {f6_hi3_reg, 32'b0});
            f7_q1p5_reg <= f6_q1p5_reg;
            f7_q1p2_reg <= f6_q1p2_reg;
            f8_q2_reg   <= f7_t6_reg + (f7_q1p5_reg <<< 17) + (64'(p4) <<< 35);
            f8_q1b_reg  <= (f7_t3_reg >>> 8) + (f7_q1p2_reg <<< 12);
            f9_lo1_reg  <= 48'(q1c_next[31:0]) * 48'(p1);
            f9_hi1_reg  <= q1c_next[63:32] * 32'(p1);
            f9_num0_reg <= (64'(PRESS_FULL_SCALE - 21'(f8_adcp_reg)) << 31) - f8_q2_reg;
            f10_d_reg   <= dsum_next[63:33];
            f10_lon_reg <= 44'(f9_num0_reg[31:0]) * 44'(PRESS_SCALE);
            f10_hin_reg <= f9_num0_reg[63:32] * 32'(PRESS_SCALE);

            // Humidity, all wrapping at 32 bits.
            f4_hv_reg  <= f3_tfine_reg - T_FINE_HUM_OFS;
            f5_x0_reg  <= 32'({f4_adch_reg, 14'b0}) - (32'(h4) <<< 20)
                          - f4_hv_reg * 32'(h5) + 32'sd16384;
            f5_m6_reg  <= f4_hv_reg * 32'(h6);
            f5_m3_reg  <= f4_hv_reg * $signed(32'(h3));
            f6_x_reg   <= f5_x0_reg >>> 15;
            f6_y1_reg  <= (f5_m6_reg >>> 10) * ((f5_m3_reg >>> 11) + 32'sd32768);
            f7_x_reg   <= f6_x_reg;
            f7_y3_reg  <= ((f6_y1_reg >>> 10) + 32'sd2097152) * 32'(h2) + 32'sd8192;
            f8_vv_reg  <= f7_x_reg * (f7_y3_reg >>> 14);
            f9_vv_reg  <= f8_vv_reg;
            f9_ww_reg  <= w_next * w_next;
            f10_vv_reg <= f9_vv_reg;
            f10_th_reg <= (f9_ww_reg >>> 7) * $signed(32'(h1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign out = out_reg;

endmodule

// File: hw/rtl/hptc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_div
// Pipelined restoring divider: one quotient bit per stage, 64 stages.
// ----------------------------------------------------------------------------
module hptc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  hptc_pkg::div_in_t  in,
    output hptc_pkg::div_out_t out
);
    import hptc_pkg::*;

    localparam int STAGES = 64;

    typedef struct packed {
        logic        vld;
        logic [63:0] nq;   // dividend bits shift out the top, quotient bits in the bottom
        logic [30:0] rem;
        logic [30:0] den;
        logic        neg;
        logic [15:0] temp;
        logic [9:0]  hum;
        logic        err;
    } div_stage_t;

    div_stage_t stg_reg [1:STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        div_stage_t cur;
        div_stage_t nxt;
        logic [31:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign cur = '{vld: in.vld, nq: in.num_mag, rem: '0, den: in.den_mag,
                           neg: in.neg, temp: in.temp, hum: in.hum, err: in.err};
        end else begin : g_rest
            assign cur = stg_reg[k];
        end

        always_comb begin
            trial    = {cur.rem, cur.nq[63]};
            ge       = (trial >= {1'b0, cur.den});
            nxt      = cur;
            nxt.nq   = {cur.nq[62:0], ge};
            nxt.rem  = ge ? 31'(trial - {1'b0, cur.den}) : trial[30:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[k+1].vld <= 1'b0;
            end else if (en) begin
                stg_reg[k+1] <= nxt;
            end
        end
    end

    assign out.vld  = stg_reg[STAGES].vld;
    assign out.quot = stg_reg[STAGES].nq;
    assign out.neg  = stg_reg[STAGES].neg;
    assign out.temp = stg_reg[STAGES].temp;
    assign out.hum  = stg_reg[STAGES].hum;
    assign out.err  = stg_reg[STAGES].err;

endmodule

// File: hw/rtl/hptc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_back
// Seven-stage back end: pressure correction terms, scaling and saturation.
// ----------------------------------------------------------------------------
module hptc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  hptc_pkg::cfg_t     cfg,
    input  hptc_pkg::div_out_t in,
    output hptc_pkg::result_t  out
);
    import hptc_pkg::*;

    logic signed [15:0] p7, p8, p9;
    assign p7 = $signed(cfg.press_hi[47:32]);
    assign p8 = $signed(cfg.press_hi[63:48]);
    assign p9 = $signed(cfg.mixed[15:0]);

    logic [5:0]         vld_reg;
    logic [15:0]        temp_reg [1:6];
    logic [9:0]         hum_reg  [1:6];
    logic               err_reg  [1:6];

    logic signed [63:0] b1_p_reg, b2_p_reg, b3_p_reg, b4_p_reg, b5_p_reg;
    logic signed [63:0] b2_lo9_reg, b2_lo8_reg;
    logic [31:0]        b2_hi9_reg, b2_hi8_reg;
    logic signed [63:0] b3_a9_reg, b3_q2_reg, b4_q2_reg, b5_q2_reg;
    logic [63:0]        b4_ll_reg;
    logic [31:0]        b4_lh_reg, b4_hl_reg;
    logic signed [63:0] b5_q1_reg, b6_pp_reg;
    result_t            out_reg;

    logic signed [63:0] s1_next, s3_next, prod_next, pa_next, p8p_next;
    result_t            out_next;

    always_comb begin
        s1_next   = b1_p_reg >>> 13;
        s3_next   = b3_p_reg >>> 13;
        p8p_next  = $signed(b2_lo8_reg + {b2_hi8_reg, 32'b0});
        prod_next = $signed(b4_ll_reg + {b4_lh_reg + b4_hl_reg, 32'b0});
        pa_next   = b6_pp_reg >>> 8;

        out_next.vld  = vld_reg[5];
        out_next.temp = temp_reg[6];
        out_next.err  = err_reg[6];
        out_next.hum  = err_reg[6] ? '0 : hum_reg[6];
        if (err_reg[6] || pa_next < 0) begin
            out_next.press = '0;
        end else if (pa_next > 64'(PRESS_MAX)) begin
            out_next.press = PRESS_MAX;
        end else begin
            out_next.press = pa_next[19:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_reg.vld <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in.vld};
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg[1] <= in.temp;
            hum_reg[1]  <= in.hum;
            err_reg[1]  <= in.err;
            for (int i = 2; i <= 6; i++) begin
                temp_reg[i] <= temp_reg[i-1];
                hum_reg[i]  <= hum_reg[i-1];
                err_reg[i]  <= err_reg[i-1];
            end

            b1_p_reg   <= in.neg ? -$signed(in.quot) : $signed(in.quot);
            b2_lo9_reg <= 64'($signed({1'b0, s1_next[31:0]})) * 64'(p9);
            b2_hi9_reg <= s1_next[63:32] * 32'(p9);
            b2_lo8_reg <= 64'($signed({1'b0, b1_p_reg[31:0]})) * 64'(p8);
            b2_hi8_reg <= b1_p_reg[63:32] * 32'(p8);
            b2_p_reg   <= b1_p_reg;
            b3_a9_reg  <= $signed(b2_lo9_reg + {b2_hi9_reg, 32'b0});
            b3_q2_reg  <= p8p_next >>> 19;
            b3_p_reg   <= b2_p_reg;
            // Low 64 bits of a 64-by-64 product from three 32-by-32 partials.
            b4_ll_reg  <= 64'(b3_a9_reg[31:0]) * 64'(s3_next[31:0]);
            b4_lh_reg  <= b3_a9_reg[31:0] * s3_next[63:32];
            b4_hl_reg  <= b3_a9_reg[63:32] * s3_next[31:0];
            b4_q2_reg  <= b3_q2_reg;
            b4_p_reg   <= b3_p_reg;
            b5_q1_reg  <= prod_next >>> 25;
            b5_q2_reg  <= b4_q2_reg;
            b5_p_reg   <= b4_p_reg;
            b6_pp_reg  <= ((b5_p_reg + b5_q1_reg + b5_q2_reg) >>> 8) + (64'(p7) <<< 4);
        end
    end

    assign out = out_reg;

endmodule

// File: hw/rtl/humidity_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_pressure_temp_compensation
// Integer compensation of raw pressure, temperature and humidity readings.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         raw pressure, raw temperature, raw humidity
//  m_axis    out        temperature, pressure, humidity; tuser = divisor error
//  cfg_wr    in         calibration coefficient registers, write only
//
//  One reading enters per cycle while s_tready is high; the result passes
//  through 11 front stages, 64 divider stages (one quotient bit each), 7
//  back stages and the two-entry output buffer. The pipeline advances as a
//  whole while the output buffer has a free entry. Reset clears all valid
//  bits and the coefficients.
// ----------------------------------------------------------------------------
module humidity_pressure_temp_compensation (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [19:0] raw_pressure, [39:20] raw_temperature, [55:40] raw_humidity
    input  logic [55:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] temperature_tenths, [35:16] pressure_pascal,
    // [45:36] humidity_tenths, [47:46] zero
    output logic [47:0]                        m_tdata,
    // [0] divisor_error
    output logic                               m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [hptc_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [hptc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import hptc_pkg::*;

    cfg_t     cfg_reg;
    div_in_t  front_out;
    div_out_t div_out;
    result_t  back_out;

    result_t  buf_reg [0:1];
    logic     wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic     en, push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_TEMP:     cfg_reg.temp     <= cfg_wr_data[47:0];
                CFG_PRESS_LO: cfg_reg.press_lo <= cfg_wr_data;
                CFG_PRESS_HI: cfg_reg.press_hi <= cfg_wr_data;
                CFG_MIXED:    cfg_reg.mixed    <= cfg_wr_data[47:0];
                CFG_HUM:      cfg_reg.hum      <= cfg_wr_data[31:0];
                default:      ;
            endcase
        end
    end

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    hptc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .cfg      (cfg_reg),
        .in_vld   (s_tvalid),
        .in_adc_p (s_tdata[19:0]),
        .in_adc_t (s_tdata[39:20]),
        .in_adc_h (s_tdata[55:40]),
        .out      (front_out)
    );

    hptc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in      (front_out),
        .out     (div_out)
    );

    hptc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .cfg     (cfg_reg),
        .in      (div_out),
        .out     (back_out)
    );

    // Two-entry output buffer decouples the downstream ready from the pipeline.
    assign push     = en && back_out.vld;
    assign pop      = m_tvalid && m_tready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= back_out;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {2'b00, buf_reg[rd_ptr_reg].hum, buf_reg[rd_ptr_reg].press,
                       buf_reg[rd_ptr_reg].temp};
    assign m_tuser  = buf_reg[rd_ptr_reg].err;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[45:16] == '0)
        else $error("divisor error result carries nonzero pressure or humidity");

    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[45:36] <= 10'd1000)
        else $error("humidity above full scale");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 && !m_tready |=> cnt_reg == 2'd2 && !s_tready)
        else $error("full output buffer did not hold the pipeline");

endmodule

// File: tb/tb_humidity_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_pressure_temp_compensation
// Self-checking bench for the environment sensor compensation pipeline.
// ----------------------------------------------------------------------------
// Raw readings stream in under several calibration sets: reset values, which
// force the divisor error, typical sensor values, all ones and random words.
// Each accepted reading is run through an in-bench integer model. Every
// result transfer is checked in order against the oldest prediction. Both
// sides of the stream stall at random, except during one quiet phase.
// ----------------------------------------------------------------------------
module tb_humidity_pressure_temp_compensation;
    import hptc_pkg::*;

    typedef struct packed {
        logic [19:0] press;
        logic [19:0] temp;
        logic [15:0] hum;
    } reading_t;

    typedef struct packed {
        logic [15:0] temp;
        logic [19:0] press;
        logic [9:0]  hum;
        logic        err;
    } comp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    reading_t pending_q[$];
    comp_t    expected_q[$];
    cfg_t     coeffs;
    logic     calm;
    int       mismatches;
    int       checked;
    int       div_errors;

    humidity_pressure_temp_compensation u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] asr32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic comp_t compensate(reading_t r, cfg_t c);
        logic [31:0] a, b, v1, v2, tf, tc, x, y, v, w;
        logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] q1, q2, p, pa, num, un, ud, uq;
        int          tq, sv;
        comp_t       res;
        t1 = {16'b0, c.temp[15:0]};
        t2 = 32'($signed(c.temp[31:16]));
        t3 = 32'($signed(c.temp[47:32]));
        p1 = {48'b0, c.press_lo[15:0]};
        p2 = 64'($signed(c.press_lo[31:16]));
        p3 = 64'($signed(c.press_lo[47:32]));
        p4 = 64'($signed(c.press_lo[63:48]));
        p5 = 64'($signed(c.press_hi[15:0]));
        p6 = 64'($signed(c.press_hi[31:16]));
        p7 = 64'($signed(c.press_hi[47:32]));
        p8 = 64'($signed(c.press_hi[63:48]));
        p9 = 64'($signed(c.mixed[15:0]));
        h1 = {24'b0, c.mixed[23:16]};
        h2 = 32'($signed(c.mixed[39:24]));
        h3 = {24'b0, c.mixed[47:40]};
        h4 = 32'($signed(c.hum[11:0]));
        h5 = 32'($signed(c.hum[23:12]));
        h6 = 32'($signed(c.hum[31:24]));
        res = '0;

        // Temperature, with the raw difference taken as signed.
        a  = {15'b0, r.temp[19:3]} - (t1 << 1);
        v1 = asr32(a * t2, 11);
        b  = {16'b0, r.temp[19:4]} - t1;
        v2 = asr32(asr32(b * b, 12) * t3, 14);
        tf = v1 + v2;
        tc = asr32(tf * 32'd5 + 32'd128, 8);
        tq = $signed(tc) / 10;
        if (tq > 32767) tq = 32767;
        if (tq < -32768) tq = -32768;
        res.temp = tq[15:0];

        // Pressure denominator; zero means no pressure and no humidity.
        q1 = 64'($signed(tf)) - 64'd128000;
        q2 = q1 * q1 * p6;
        q2 = q2 + ((q1 * p5) << 17);
        q2 = q2 + (p4 << 35);
        q1 = asr64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
        q1 = asr64(((64'd1 << 47) + q1) * p1, 33);
        if (q1 == 64'd0) begin
            res.err = 1'b1;
            return res;
        end
        p   = 64'd1048576 - {44'b0, r.press};
        num = ((p << 31) - q2) * 64'd3125;
        un  = num[63] ? -num : num;
        ud  = q1[63] ? -q1 : q1;
        uq  = un / ud;
        p   = (num[63] != q1[63]) ? -uq : uq;
        q1  = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
        q2  = asr64(p8 * p, 19);
        p   = asr64(p + q1 + q2, 8) + (p7 << 4);
        pa  = asr64(p, 8);
        if (pa[63])
            res.press = '0;
        else if (pa > 64'd1048575)
            res.press = 20'hFFFFF;
        else
            res.press = pa[19:0];

        // Humidity.
        v = tf - 32'd76800;
        x = ({16'b0, r.hum} << 14) - (h4 << 20) - h5 * v + 32'd16384;
        x = asr32(x, 15);
        y = asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768);
        y = asr32(y, 10) + 32'd2097152;
        y = asr32(y * h2 + 32'd8192, 14);
        v = x * y;
        w = asr32(v, 15);
        v = v - asr32(asr32(w * w, 7) * h1, 4);
        sv = $signed(v);
        if (sv < 0) sv = 0;
        if (sv > 419430400) sv = 419430400;
        uq = (64'(sv) * 64'd10) >> 22;
        res.hum = uq[9:0];
        return res;
    endfunction

    // Sender: present the next pending reading, or idle now and then.
    always @(posedge aclk) begin
        reading_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(compensate(
                    reading_t'({s_tdata[19:0], s_tdata[39:20], s_tdata[55:40]}), coeffs));
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.hum, nxt.temp, nxt.press};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transfer and stall at random.
    always @(posedge aclk) begin
        comp_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[35:16], m_tdata[45:36], m_tuser};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result %h", $realtime, got);
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.err) div_errors++;
                    if (got.temp !== want.temp) begin
                        mismatches++;
                        $display("%0t: temperature expected %0d got %0d", $realtime,
                                 $signed(want.temp), $signed(got.temp));
                    end
                    if (got.press !== want.press) begin
                        mismatches++;
                        $display("%0t: pressure expected %0d got %0d", $realtime,
                                 want.press, got.press);
                    end
                    if (got.hum !== want.hum) begin
                        mismatches++;
                        $display("%0t: humidity expected %0d got %0d", $realtime,
                                 want.hum, got.hum);
                    end
                    if (got.err !== want.err) begin
                        mismatches++;
                        $display("%0t: divisor error expected %0b got %0b", $realtime,
                                 want.err, got.err);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 18);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            CFG_TEMP:     coeffs.temp     = val[47:0];
            CFG_PRESS_LO: coeffs.press_lo = val;
            CFG_PRESS_HI: coeffs.press_hi = val;
            CFG_MIXED:    coeffs.mixed    = val[47:0];
            CFG_HUM:      coeffs.hum      = val[31:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_coeffs(cfg_t c);
        write_reg(CFG_TEMP, {16'b0, c.temp});
        write_reg(CFG_PRESS_LO, c.press_lo);
        write_reg(CFG_PRESS_HI, c.press_hi);
        write_reg(CFG_MIXED, {16'b0, c.mixed});
        write_reg(CFG_HUM, {32'b0, c.hum});
    endtask

    // Let every reading drain and the pipeline settle before touching registers.
    task automatic drain();
        while (pending_q.size() != 0 || expected_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic reading_t any_reading();
        return {20'($urandom), 20'($urandom), 16'($urandom)};
    endfunction

    // Readings near a plausible operating point, with some fully random ones.
    function automatic reading_t near_reading();
        reading_t r;
        if ($urandom_range(9) == 0) return any_reading();
        r.press = 20'(415148 + $signed($urandom_range(200000)) - 100000);
        r.temp  = 20'(519888 + $signed($urandom_range(200000)) - 100000);
        r.hum   = 16'(32000 + $signed($urandom_range(30000)) - 15000);
        return r;
    endfunction

    task automatic queue_random(int count);
        repeat (count) pending_q.push_back(near_reading());
    endtask

    initial begin
        cfg_t typical, c;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        calm         = 1'b0;
        coeffs       = '0;
        mismatches   = 0;
        checked      = 0;
        div_errors   = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset coefficients give a zero divisor on every reading.
        pending_q.push_back('0);
        pending_q.push_back('1);
        repeat (6) pending_q.push_back(any_reading());
        drain();

        typical.temp     = {16'(-1000), 16'(26435), 16'(27504)};
        typical.press_lo = {16'(2855), 16'(3024), 16'(-10685), 16'(36477)};
        typical.press_hi = {16'(-14600), 16'(15500), 16'(-7), 16'(140)};
        typical.mixed    = {8'(0), 16'(362), 8'(75), 16'(6000)};
        typical.hum      = {8'(30), 12'(50), 12'(313)};
        load_coeffs(typical);
        // An index past the register list must leave everything unchanged.
        write_reg(CFG_IDX_W'(CFG_HUM) + 1'b1, '1);
        pending_q.push_back('0);
        pending_q.push_back('1);
        pending_q.push_back({20'd415148, 20'd519888, 16'd32000});
        pending_q.push_back({20'hFFFFF, 20'd0, 16'hFFFF});
        pending_q.push_back({20'd0, 20'hFFFFF, 16'd0});
        pending_q.push_back({20'd415148, 20'd0, 16'hFFFF});
        pending_q.push_back({20'd415148, 20'hFFFFF, 16'd0});
        pending_q.push_back({20'h80000, 20'h80000, 16'h8000});
        queue_random(400);
        drain();

        // Same calibration with no stalls on either side.
        calm = 1'b1;
        queue_random(300);
        drain();
        calm = 1'b0;

        // All coefficients at their top and bottom codes.
        load_coeffs('1);
        pending_q.push_back('0);
        pending_q.push_back('1);
        queue_random(150);
        drain();
        c = typical;
        c.temp[47:32] = 16'h8000;
        c.press_lo[15:0] = 16'hFFFF;
        c.press_hi[15:0] = 16'h8000;
        c.mixed[23:16] = 8'hFF;
        c.hum = 32'h80800800;
        load_coeffs(c);
        queue_random(150);
        drain();

        // Perturbed typical sets, then fully random words.
        repeat (4) begin
            c = typical;
            c.temp[47:16]     = c.temp[47:16] ^ 32'($urandom_range(255));
            c.press_lo[63:16] = c.press_lo[63:16] ^ 48'($urandom_range(1023));
            c.press_hi        = c.press_hi ^ 64'($urandom_range(4095));
            c.mixed           = c.mixed ^ 48'($urandom);
            c.hum             = $urandom;
            load_coeffs(c);
            queue_random(150);
            drain();
        end
        repeat (2) begin
            c = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
            load_coeffs(c);
            queue_random(100);
            drain();
        end

        $display("Checked %0d results over ten calibration sets, %0d with divisor error.",
                 checked, div_errors);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results still expected", expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
